>>> hdl/order_book_matcher_macros.svh
// Assertion macros for the order book matcher.
`ifndef ORDER_BOOK_MATCHER_MACROS_SVH
`define ORDER_BOOK_MATCHER_MACROS_SVH

// same-cycle implication
`define OBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/obm_pkg.sv
// Shared types and constants of the order book matcher.
package obm_pkg;

    localparam int TICK_W  = 10;
    localparam int PRICE_W = 20;
    localparam int QTY_W   = 16;

    localparam int DEF_ORDER_SLOTS = 64;
    localparam int DEF_TICKERS     = 1024;
    localparam int DEF_PRICE_BITS  = 20;
    localparam int DEF_QTY_BITS    = 16;

    localparam logic [5:0] MAX_FILLS = 6'd63;

    typedef enum logic [1:0] {
        KIND_ADD_OK  = 2'd0,
        KIND_ADD_REJ = 2'd1,
        KIND_TRADE   = 2'd2,
        KIND_DONE    = 2'd3
    } obm_kind_t;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_MATCH = 1'b1;
    localparam logic SIDE_BUY   = 1'b1;
    localparam logic SIDE_SELL  = 1'b0;

    typedef struct packed {
        logic               mode;
        logic               side;
        logic [TICK_W-1:0]  ticker;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
    } obm_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TICK_W-1:0]  trade_ticker;
        logic [PRICE_W-1:0] buy_price;
        logic [PRICE_W-1:0] sell_price;
        logic [QTY_W-1:0]   traded_quantity;
        logic               last;
    } obm_result_t;

endpackage

>>> hdl/order_book_matcher.sv
// Order book matcher: resting limit order store with price-priority matching.
//
// Input channel item/item_valid/item_stall carries one word per request: add an
// order (mode 0) or match a ticker (mode 1). Output channel result/result_valid/
// result_stall carries result words; last marks the final word of a request.
// A word is taken when valid is high and stall is low.
// Add: the result is registered on acceptance; the free slot used is the lowest.
// Match: each search walks the order memory, one slot per cycle through its
// single read port; each fill needs a full walk, and the final done word
// follows a closing walk. One request is in work at a time and the next
// is taken once the current one has issued its last word.
// A result waits in the output register while result_stall is high; the block
// keeps walking the memory and holds only when it next needs that register,
// accepting nothing new until the register can be freed.
// Reset (rst_n low) empties the store at once: all slot valid bits clear, no
// memory sweep is needed since entries are read only when valid.
`include "order_book_matcher_macros.svh"

module order_book_matcher
    import obm_pkg::*;
#(
    parameter int ORDER_SLOTS = DEF_ORDER_SLOTS,
    parameter int TICKERS     = DEF_TICKERS,
    parameter int PRICE_BITS  = DEF_PRICE_BITS,
    parameter int QTY_BITS    = DEF_QTY_BITS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  obm_item_t   item,
    input  logic        item_valid,
    output logic        item_stall,
    output obm_result_t result,
    output logic        result_valid,
    input  logic        result_stall
);

    localparam int SW = $clog2(ORDER_SLOTS);
    localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int QW = (QTY_BITS < QTY_W) ? QTY_BITS : QTY_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(ORDER_SLOTS - 1);

    typedef struct packed {
        logic              side;
        logic [TICK_W-1:0] ticker;
        logic [QW-1:0]     qty;
        logic [PW-1:0]     price;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_WRB, ST_WRA
    } state_t;

    state_t state_reg;

    entry_t mem [ORDER_SLOTS];
    entry_t rd_data_reg;
    logic [SW-1:0] rd_addr;
    logic          mem_we;
    logic [SW-1:0] wr_addr;
    entry_t        wr_data;

    logic [ORDER_SLOTS-1:0] slot_valid_reg;
    logic [SW-1:0]     scan_idx_reg;
    logic              rd_vld_reg;
    logic [SW-1:0]     rd_slot_reg;
    logic [TICK_W-1:0] req_ticker_reg;
    logic [5:0]        fills_reg;

    logic              bid_found_reg, ask_found_reg;
    logic [SW-1:0]     bid_idx_reg, ask_idx_reg;
    logic [PW-1:0]     bid_price_reg, ask_price_reg;
    logic [QW-1:0]     bid_qty_reg, ask_qty_reg;

    obm_result_t result_reg;
    logic        result_valid_reg;

    logic          out_free, in_acc;
    logic [SW-1:0] free_idx;
    logic          free_found;
    logic [QW-1:0] item_qty;
    logic [PW-1:0] item_price;
    logic          ticker_ok;
    logic          add_ok;
    logic [QW-1:0] trade_qty;
    logic          do_trade;
    logic          hit;

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_acc     = item_valid && !item_stall;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign item_qty   = item.quantity[QW-1:0];
    assign item_price = item.price[PW-1:0];
    assign ticker_ok  = 32'(item.ticker) < TICKERS;
    assign add_ok     = free_found && ticker_ok && (item_qty != '0);
    assign trade_qty  = (bid_qty_reg < ask_qty_reg) ? bid_qty_reg : ask_qty_reg;
    assign do_trade   = bid_found_reg && ask_found_reg && (bid_price_reg >= ask_price_reg)
                        && (fills_reg != MAX_FILLS);
    assign hit        = rd_vld_reg && slot_valid_reg[rd_slot_reg]
                        && (rd_data_reg.ticker == req_ticker_reg);

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_addr = scan_idx_reg;
        mem_we  = 1'b0;
        wr_addr = bid_idx_reg;
        wr_data = '{side: SIDE_BUY, ticker: req_ticker_reg,
                    qty: bid_qty_reg - trade_qty, price: bid_price_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we  = in_acc && (item.mode == MODE_ADD) && add_ok;
                wr_addr = free_idx;
                wr_data = '{side: item.side, ticker: item.ticker,
                            qty: item_qty, price: item_price};
            end
            ST_WRB:
            begin
                mem_we = out_free;
            end
            ST_WRA:
            begin
                mem_we  = 1'b1;
                wr_addr = ask_idx_reg;
                wr_data = '{side: SIDE_SELL, ticker: req_ticker_reg,
                            qty: ask_qty_reg - trade_qty, price: ask_price_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hit && (rd_data_reg.side == SIDE_BUY) &&
            (!bid_found_reg || (rd_data_reg.price > bid_price_reg)))
        begin
            bid_idx_reg   <= rd_slot_reg;
            bid_price_reg <= rd_data_reg.price;
            bid_qty_reg   <= rd_data_reg.qty;
        end
        if (hit && (rd_data_reg.side == SIDE_SELL) &&
            (!ask_found_reg || (rd_data_reg.price < ask_price_reg)))
        begin
            ask_idx_reg   <= rd_slot_reg;
            ask_price_reg <= rd_data_reg.price;
            ask_qty_reg   <= rd_data_reg.qty;
        end
        rd_slot_reg <= scan_idx_reg;
        if (in_acc)
        begin
            req_ticker_reg <= item.ticker;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_valid_reg   <= '0;
            scan_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            fills_reg        <= '0;
            bid_found_reg    <= 1'b0;
            ask_found_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (hit && (rd_data_reg.side == SIDE_BUY))
            begin
                bid_found_reg <= 1'b1;
            end
            if (hit && (rd_data_reg.side == SIDE_SELL))
            begin
                ask_found_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (item.mode == MODE_ADD)
                        begin
                            if (add_ok)
                            begin
                                slot_valid_reg[free_idx] <= 1'b1;
                            end
                            result_valid_reg <= 1'b1;
                            result_reg <= '{kind: add_ok ? KIND_ADD_OK : KIND_ADD_REJ,
                                            trade_ticker: item.ticker, buy_price: '0,
                                            sell_price: '0, traded_quantity: '0,
                                            last: 1'b1};
                        end
                        else if (!ticker_ok)
                        begin
                            result_valid_reg <= 1'b1;
                            result_reg <= '{kind: KIND_DONE, trade_ticker: item.ticker,
                                            buy_price: '0, sell_price: '0,
                                            traded_quantity: '0, last: 1'b1};
                        end
                        else
                        begin
                            fills_reg     <= '0;
                            scan_idx_reg  <= '0;
                            bid_found_reg <= 1'b0;
                            ask_found_reg <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_SCAN_END;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_SCAN_END:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (do_trade)
                    begin
                        state_reg <= ST_WRB;
                    end
                    else if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        result_reg <= '{kind: KIND_DONE, trade_ticker: req_ticker_reg,
                                        buy_price: '0, sell_price: '0,
                                        traded_quantity: '0, last: 1'b1};
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WRB:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        result_reg <= '{kind: KIND_TRADE, trade_ticker: req_ticker_reg,
                                        buy_price: PRICE_W'(bid_price_reg),
                                        sell_price: PRICE_W'(ask_price_reg),
                                        traded_quantity: QTY_W'(trade_qty), last: 1'b0};
                        if (bid_qty_reg == trade_qty)
                        begin
                            slot_valid_reg[bid_idx_reg] <= 1'b0;
                        end
                        fills_reg <= fills_reg + 1'b1;
                        state_reg <= ST_WRA;
                    end
                end
                ST_WRA:
                begin
                    if (ask_qty_reg == trade_qty)
                    begin
                        slot_valid_reg[ask_idx_reg] <= 1'b0;
                    end
                    scan_idx_reg  <= '0;
                    bid_found_reg <= 1'b0;
                    ask_found_reg <= 1'b0;
                    state_reg     <= ST_SCAN;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `OBM_ASSERT_NOW(a_trade_crossed, state_reg == ST_WRB,
        bid_found_reg && ask_found_reg && (bid_price_reg >= ask_price_reg),
        "trade on uncrossed book")
    `OBM_ASSERT_NOW(a_mem_write_src,
        mem_we && (state_reg != ST_IDLE),
        (state_reg == ST_WRB) || (state_reg == ST_WRA),
        "memory write outside write states")
    `OBM_ASSERT_NEXT(a_wrb_to_wra, (state_reg == ST_WRB) && out_free,
        state_reg == ST_WRA, "ask write-back skipped")
    `OBM_ASSERT_NOW(a_trade_nonzero, state_reg == ST_WRB,
        trade_qty != '0, "zero quantity trade")

endmodule

>>> verif/order_book_matcher_tb.sv
// Testbench for order_book_matcher: directed and random order flow checked against a book model.
`timescale 1ns / 100ps

module order_book_matcher_tb;
    import obm_pkg::*;

    localparam int SLOTS      = DEF_ORDER_SLOTS;
    localparam int WDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    obm_item_t   item;
    logic        item_valid;
    logic        item_stall;
    obm_result_t result;
    logic        result_valid;
    logic        result_stall;

    order_book_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    bit                 book_live  [SLOTS];
    logic               book_side  [SLOTS];
    logic [TICK_W-1:0]  book_tick  [SLOTS];
    logic [QTY_W-1:0]   book_qty   [SLOTS];
    logic [PRICE_W-1:0] book_price [SLOTS];

    obm_result_t pending_results[$];
    int          errors;
    int          words_sent;
    int          words_seen;
    int          trades_seen;
    int          idle_cycles;
    bit          sink_stall_on;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int best_order(logic [TICK_W-1:0] tick, logic buy);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (book_live[i] && book_tick[i] == tick && book_side[i] == buy)
            begin
                if (best < 0)
                    best = i;
                else if (buy ? (book_price[i] > book_price[best])
                             : (book_price[i] < book_price[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic obm_result_t mk_result(obm_kind_t k, logic [TICK_W-1:0] tick,
                                              logic [PRICE_W-1:0] bp,
                                              logic [PRICE_W-1:0] sp,
                                              logic [QTY_W-1:0] q, logic lst);
        obm_result_t r;
        r.kind            = k;
        r.trade_ticker    = tick;
        r.buy_price       = bp;
        r.sell_price      = sp;
        r.traded_quantity = q;
        r.last            = lst;
        return r;
    endfunction

    function automatic void queue_result(obm_result_t r);
        pending_results = {pending_results, r};
    endfunction

    task automatic book_apply(obm_item_t it);
        int freeslot;
        int b;
        int s;
        int n;
        logic [QTY_W-1:0] t;
        freeslot = -1;
        if (it.mode == MODE_ADD)
        begin
            if (it.quantity != 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!book_live[i] && freeslot < 0)
                        freeslot = i;
                end
            end
            if (freeslot < 0)
                queue_result(mk_result(KIND_ADD_REJ, it.ticker, '0, '0, '0, 1'b1));
            else
            begin
                book_live[freeslot]  = 1'b1;
                book_side[freeslot]  = it.side;
                book_tick[freeslot]  = it.ticker;
                book_qty[freeslot]   = it.quantity;
                book_price[freeslot] = it.price;
                queue_result(mk_result(KIND_ADD_OK, it.ticker, '0, '0, '0, 1'b1));
            end
        end
        else
        begin
            n = 0;
            while (n < int'(MAX_FILLS))
            begin
                b = best_order(it.ticker, SIDE_BUY);
                s = best_order(it.ticker, SIDE_SELL);
                if (b < 0 || s < 0 || book_price[b] < book_price[s])
                    break;
                t = (book_qty[b] < book_qty[s]) ? book_qty[b] : book_qty[s];
                book_qty[b] -= t;
                book_qty[s] -= t;
                queue_result(mk_result(KIND_TRADE, it.ticker, book_price[b],
                                       book_price[s], t, 1'b0));
                n++;
                if (book_qty[b] == 0)
                    book_live[b] = 1'b0;
                if (book_qty[s] == 0)
                    book_live[s] = 1'b0;
            end
            queue_result(mk_result(KIND_DONE, it.ticker, '0, '0, '0, 1'b1));
        end
    endtask

    task automatic send_word(obm_item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        book_apply(it);
        words_sent++;
    endtask

    task automatic send_add(logic sd, logic [TICK_W-1:0] tk, logic [QTY_W-1:0] q,
                            logic [PRICE_W-1:0] p);
        obm_item_t it;
        it.mode     = MODE_ADD;
        it.side     = sd;
        it.ticker   = tk;
        it.quantity = q;
        it.price    = p;
        send_word(it);
    endtask

    task automatic send_match(logic [TICK_W-1:0] tk, logic sd);
        obm_item_t it;
        it.mode     = MODE_MATCH;
        it.side     = sd;
        it.ticker   = tk;
        it.quantity = 16'($urandom);
        it.price    = 20'($urandom);
        send_word(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
    endtask

    // extremes, ties, zero quantity, no-cross match, either side on match
    task automatic test_directed();
        send_add(SIDE_BUY, 10'd1023, 16'hFFFF, 20'hFFFFF);
        send_add(SIDE_SELL, 10'd1023, 16'd1, 20'd0);
        send_add(SIDE_SELL, 10'd1023, 16'd0, 20'd5);
        send_match(10'd1023, SIDE_BUY);
        send_match(10'd1023, SIDE_SELL);
        send_add(SIDE_BUY, 10'd0, 16'd5, 20'd100);
        send_add(SIDE_BUY, 10'd0, 16'd7, 20'd100);
        send_add(SIDE_SELL, 10'd0, 16'd3, 20'd90);
        send_add(SIDE_SELL, 10'd0, 16'd20, 20'd90);
        send_add(SIDE_SELL, 10'd0, 16'd4, 20'd101);
        send_match(10'd0, SIDE_SELL);
        send_match(10'd5, SIDE_BUY);
        send_add(SIDE_BUY, 10'd0, 16'd1, 20'd50);
        send_match(10'd0, SIDE_BUY);
        send_add(SIDE_SELL, 10'h2AA, 16'hAAAA, 20'hAAAAA);
        send_add(SIDE_BUY, 10'h155, 16'h5555, 20'h55555);
        send_match(10'h2AA, SIDE_BUY);
        drain();
    endtask

    // fill the store, check rejection when full, then sweep it with matches
    task automatic test_store_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_add(logic'(i % 2), 10'd7, 16'($urandom_range(1, 9)),
                     20'($urandom_range(1000, 1010)));
        send_add(SIDE_SELL, 10'd8, 16'd1, 20'd1);
        send_match(10'd7, SIDE_BUY);
        for (int t = 0; t < 1024; t += 1)
        begin
            if (t == 0 || t == 7 || t == 1023 || t == 5 || t == 8 || t == 682 || t == 341)
                send_match(10'(t), SIDE_SELL);
        end
        drain();
    endtask

    // well-formed books on a few tickers with crossing prices, plus noise
    task automatic test_random();
        logic [TICK_W-1:0] tk;
        int kind;
        for (int n = 0; n < 80; n++)
        begin
            kind = $urandom_range(0, 99);
            tk   = (kind < 90) ? 10'($urandom_range(0, 3)) : 10'($urandom);
            if (kind < 72)
                send_add(logic'($urandom), tk,
                         ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50)),
                         ($urandom_range(0, 19) == 0) ? 20'($urandom)
                                                      : 20'($urandom_range(990, 1010)));
            else
                send_match(tk, logic'($urandom));
        end
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall  <= 1'b0;
            sink_stall_on <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 3)
                sink_stall_on <= ~sink_stall_on;
            if (sink_stall_on)
                result_stall <= ($urandom_range(0, 99) < 40);
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            words_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, result);
            end
            else
            begin
                obm_result_t exp_r;
                exp_r = pending_results.pop_front();
                if (exp_r.kind == KIND_TRADE)
                    trades_seen++;
                if (result.kind != exp_r.kind ||
                    result.trade_ticker != exp_r.trade_ticker ||
                    result.buy_price != exp_r.buy_price ||
                    result.sell_price != exp_r.sell_price ||
                    result.traded_quantity != exp_r.traded_quantity ||
                    result.last != exp_r.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no progress, %0d results outstanding", pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rst_n       = 1'b0;
        item        = '0;
        item_valid  = 1'b0;
        errors      = 0;
        words_sent  = 0;
        words_seen  = 0;
        trades_seen = 0;
        idle_cycles = 0;
        for (int i = 0; i < SLOTS; i++)
            book_live[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_random();
        foreach (pending_results[i])
        begin
            errors++;
            $display("%0t: missing result %p", $time, pending_results[i]);
        end
        $display("sent %0d request words, checked %0d result words", words_sent, words_seen);
        $display("including %0d trades over directed, full-store and random books", trades_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/obm_pkg.sv
hdl/order_book_matcher.sv
verif/order_book_matcher_tb.sv
